/* rtl/ddp_packet_receiver_core_assert.svh */
// Assertion helpers, clocked on clk and quiet while rst is high.
`ifndef DDP_PACKET_RECEIVER_CORE_ASSERT_SVH
`define DDP_PACKET_RECEIVER_CORE_ASSERT_SVH

// Condition holds at every edge.
`define DDP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define DDP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define DDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ddp_rx_pkg.sv */
package ddp_rx_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_CHANNEL_COUNT = 3'd0;
  localparam logic [18:0] CHANNEL_COUNT_RESET = 19'd262144;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  // Header byte positions
  localparam logic [15:0] POS_FLAGS     = 16'd0;
  localparam logic [15:0] POS_SEQUENCE  = 16'd1;
  localparam logic [15:0] POS_ID        = 16'd3;
  localparam logic [15:0] POS_OFFSET_0  = 16'd4;
  localparam logic [15:0] POS_OFFSET_1  = 16'd5;
  localparam logic [15:0] POS_OFFSET_2  = 16'd6;
  localparam logic [15:0] POS_OFFSET_3  = 16'd7;
  localparam logic [15:0] POS_LENGTH_HI = 16'd8;
  localparam logic [15:0] POS_LENGTH_LO = 16'd9;
  localparam logic [15:0] POS_MAX       = 16'hFFFF;

  localparam logic [15:0] HDR_LEN_BASE     = 16'd10;
  localparam logic [15:0] HDR_LEN_TIMECODE = 16'd14;

  localparam int unsigned FLAG_TIMECODE_BIT = 4;
  localparam int unsigned FLAG_PUSH_BIT     = 0;

  localparam logic [7:0] ID_ACCEPT = 8'd1;

  localparam logic [3:0] SEQ_NONE  = 4'd0;
  localparam logic [3:0] SEQ_FIRST = 4'd1;
  localparam logic [3:0] SEQ_WRAP  = 4'd15;

  localparam logic [2:0] STATUS_IGNORED = 3'd0;
  localparam logic [2:0] STATUS_OK      = 3'd1;
  localparam logic [2:0] STATUS_SEQ     = 3'd2;
  localparam logic [2:0] STATUS_OVF     = 3'd3;
  localparam logic [2:0] STATUS_BOTH    = 3'd4;

  localparam logic [27:0] LOWEST_RESET = 28'hFFFFFFF;

  typedef struct packed {
    logic        fire;
    logic        seq_bad;
    logic [3:0]  seq_num;
    logic [31:0] offset;
    logic [15:0] length;
  } hdr_accept_t;

  typedef struct packed {
    logic [31:0] packets;
    logic [47:0] bytes;
    logic [31:0] errors;
    logic [27:0] min_channel;
    logic [32:0] max_channel;
  } totals_t;

  typedef struct packed {
    logic        emit;
    logic        write_valid;
    logic [17:0] write_address;
    logic [7:0]  write_data;
    logic        packet_end;
    logic [2:0]  status;
    logic        push;
  } step_result_t;

endpackage

/* rtl/ddp_rx_stats.sv */
module ddp_rx_stats (
  input  logic                    clk,
  input  logic                    rst,
  input  ddp_rx_pkg::hdr_accept_t hdr,
  output logic [3:0]              last_sequence,
  output ddp_rx_pkg::totals_t     totals_next
);

  ddp_rx_pkg::totals_t totals;
  logic [3:0]  last_sequence_next;
  logic [32:0] lo;
  logic [32:0] hi;

  always_comb begin
    lo = {1'b0, hdr.offset} + 33'd1;
    hi = {1'b0, hdr.offset} + {17'b0, hdr.length};

    totals_next = totals;
    last_sequence_next = last_sequence;
    if (hdr.fire) begin
      totals_next.packets = totals.packets + 32'd1;
      totals_next.bytes   = totals.bytes + {32'b0, hdr.length};
      totals_next.errors  = totals.errors + {31'b0, hdr.seq_bad};
      if (hdr.seq_num != ddp_rx_pkg::SEQ_NONE) begin
        last_sequence_next = hdr.seq_num;
      end
      if (lo < {5'b0, totals.min_channel}) begin
        totals_next.min_channel = lo[27:0];
      end
      if (hi > totals.max_channel) begin
        totals_next.max_channel = hi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      totals.packets     <= '0;
      totals.bytes       <= '0;
      totals.errors      <= '0;
      totals.min_channel <= ddp_rx_pkg::LOWEST_RESET;
      totals.max_channel <= '0;
      last_sequence      <= ddp_rx_pkg::SEQ_NONE;
    end else begin
      totals        <= totals_next;
      last_sequence <= last_sequence_next;
    end
  end

endmodule

/* rtl/ddp_rx_parse.sv */
module ddp_rx_parse #(
  parameter int unsigned CHANNEL_MEMORY_DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [7:0]               byte_value,
  input  logic                     first_byte,
  input  logic                     last_byte,
  input  logic [18:0]              channel_count,
  input  logic [3:0]               last_sequence,
  output ddp_rx_pkg::hdr_accept_t  hdr,
  output ddp_rx_pkg::step_result_t res
);

  localparam logic [32:0] DEPTH_W = 33'(CHANNEL_MEMORY_DEPTH);

  ddp_rx_pkg::phase_t phase, ph, phase_next;
  logic [15:0] byte_position, pos, byte_position_next;
  logic [7:0]  header_flags, flags, header_flags_next;
  logic [3:0]  packet_sequence, seq, packet_sequence_next;
  logic        packet_valid, pv, packet_valid_next;
  logic [31:0] channel_offset, off, channel_offset_next;
  logic [15:0] payload_length, len, payload_length_next;
  logic        seq_error_seen, sse, seq_error_seen_next;
  logic        overflow_seen, ovf, overflow_seen_next;
  logic [15:0] hlen;
  logic [32:0] addr;
  logic        seq_bad;

  always_comb begin
    // A first byte starts from a clean packet state.
    ph = phase; pos = byte_position; flags = header_flags; seq = packet_sequence;
    pv = packet_valid; off = channel_offset; len = payload_length;
    sse = seq_error_seen; ovf = overflow_seen;
    if (first_byte) begin
      ph = ddp_rx_pkg::PH_HEADER; pos = '0; flags = '0; seq = '0;
      pv = 1'b0; off = '0; len = '0; sse = 1'b0; ovf = 1'b0;
    end

    phase_next = ph; byte_position_next = pos; header_flags_next = flags;
    packet_sequence_next = seq; packet_valid_next = pv; channel_offset_next = off;
    payload_length_next = len; seq_error_seen_next = sse; overflow_seen_next = ovf;
    hdr = '0;
    res = '0;
    hlen = ddp_rx_pkg::HDR_LEN_BASE;
    addr = '0;
    seq_bad = 1'b0;

    unique case (ph)
      ddp_rx_pkg::PH_HEADER: begin
        case (pos) inside
          ddp_rx_pkg::POS_FLAGS:    header_flags_next = byte_value;
          ddp_rx_pkg::POS_SEQUENCE: packet_sequence_next = byte_value[3:0];
          ddp_rx_pkg::POS_ID:       packet_valid_next = (byte_value == ddp_rx_pkg::ID_ACCEPT);
          ddp_rx_pkg::POS_OFFSET_0, ddp_rx_pkg::POS_OFFSET_1,
          ddp_rx_pkg::POS_OFFSET_2, ddp_rx_pkg::POS_OFFSET_3:
            channel_offset_next = {off[23:0], byte_value};
          ddp_rx_pkg::POS_LENGTH_HI, ddp_rx_pkg::POS_LENGTH_LO:
            payload_length_next = {len[7:0], byte_value};
          default: ;
        endcase
        byte_position_next = pos + 16'd1;
        hlen = header_flags_next[ddp_rx_pkg::FLAG_TIMECODE_BIT] ?
               ddp_rx_pkg::HDR_LEN_TIMECODE : ddp_rx_pkg::HDR_LEN_BASE;
        if (byte_position_next >= hlen) begin
          // Nonzero sequence against the last one; 15 wraps to 1.
          if (packet_sequence_next != ddp_rx_pkg::SEQ_NONE &&
              last_sequence != ddp_rx_pkg::SEQ_NONE) begin
            if (packet_sequence_next == ddp_rx_pkg::SEQ_FIRST) begin
              seq_bad = (last_sequence != ddp_rx_pkg::SEQ_WRAP);
            end else begin
              seq_bad = (last_sequence != (packet_sequence_next - 4'd1));
            end
          end
          hdr.fire    = step && packet_valid_next;
          hdr.seq_bad = seq_bad;
          hdr.seq_num = packet_sequence_next;
          hdr.offset  = channel_offset_next;
          hdr.length  = payload_length_next;
          if (packet_valid_next && seq_bad) begin
            seq_error_seen_next = 1'b1;
          end
          phase_next = ddp_rx_pkg::PH_PAYLOAD;
          byte_position_next = '0;
        end
      end
      ddp_rx_pkg::PH_PAYLOAD: begin
        if (pv && pos < len) begin
          addr = {1'b0, off} + {17'b0, pos};
          if (addr < {14'b0, channel_count} && addr < DEPTH_W) begin
            res.write_valid   = 1'b1;
            res.write_address = addr[17:0];
            res.write_data    = byte_value;
          end else begin
            overflow_seen_next = 1'b1;
          end
        end
        if (pos != ddp_rx_pkg::POS_MAX) begin
          byte_position_next = pos + 16'd1;
        end
      end
      ddp_rx_pkg::PH_IDLE: ;
      default: ;
    endcase

    if (ph != ddp_rx_pkg::PH_IDLE && last_byte) begin
      res.packet_end = 1'b1;
      if (phase_next == ddp_rx_pkg::PH_PAYLOAD && packet_valid_next) begin
        case ({overflow_seen_next, seq_error_seen_next})
          2'b00:   res.status = ddp_rx_pkg::STATUS_OK;
          2'b01:   res.status = ddp_rx_pkg::STATUS_SEQ;
          2'b10:   res.status = ddp_rx_pkg::STATUS_OVF;
          default: res.status = ddp_rx_pkg::STATUS_BOTH;
        endcase
        res.push = header_flags_next[ddp_rx_pkg::FLAG_PUSH_BIT];
      end
      phase_next = ddp_rx_pkg::PH_IDLE;
      packet_valid_next = 1'b0;
    end
    res.emit = (ph != ddp_rx_pkg::PH_IDLE) && (res.write_valid || last_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ddp_rx_pkg::PH_IDLE;
      byte_position   <= '0;
      header_flags    <= '0;
      packet_sequence <= '0;
      packet_valid    <= 1'b0;
      channel_offset  <= '0;
      payload_length  <= '0;
      seq_error_seen  <= 1'b0;
      overflow_seen   <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      header_flags    <= header_flags_next;
      packet_sequence <= packet_sequence_next;
      packet_valid    <= packet_valid_next;
      channel_offset  <= channel_offset_next;
      payload_length  <= payload_length_next;
      seq_error_seen  <= seq_error_seen_next;
      overflow_seen   <= overflow_seen_next;
    end
  end

endmodule

/* rtl/ddp_packet_receiver_core.sv */
// An item accepted into the input register is parsed there; its result moves to the output
// register once that is free. Throughput: one item per cycle while the sink does not stall;
// the parse and counter update fit in one register stage; an item with no result retires.
// Reset: synchronous rst clears the pipeline, the parser and all counters;
// channel_count returns to 262144. No clearing pass is needed.
`include "ddp_packet_receiver_core_assert.svh"

module ddp_packet_receiver_core #(
  parameter int unsigned CHANNEL_MEMORY_DEPTH = 262144
) (
  input  logic        clk,
  input  logic        rst,
  // input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_value,
  input  logic        first_byte,
  input  logic        last_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_valid,
  output logic [17:0] write_address,
  output logic [7:0]  write_data,
  output logic        packet_end,
  output logic [2:0]  status,
  output logic        push_res,
  output logic [31:0] packets_total,
  output logic [47:0] bytes_total,
  output logic [31:0] errors_total,
  output logic [27:0] min_channel,
  output logic [32:0] max_channel,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [ddp_rx_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration register: only channel_count, at byte address 0.
  logic [18:0] channel_count;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr == ddp_rx_pkg::CFG_ADDR_CHANNEL_COUNT);
  assign prdata    = (paddr == ddp_rx_pkg::CFG_ADDR_CHANNEL_COUNT) ?
                     {13'b0, channel_count} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= ddp_rx_pkg::CHANNEL_COUNT_RESET;
    end else if (cfg_write) begin
      channel_count <= pwdata[18:0];
    end
  end

  // Input register. An item sits here while it is parsed, until the output register is free.
  logic       s1_full;
  logic [7:0] s1_byte;
  logic       s1_first;
  logic       s1_last;
  logic       in_take;
  logic       out_free;
  logic       advance;

  // The output register frees up this cycle when empty or when it is being taken.
  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_full && out_free;
  assign in_stall = s1_full && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_full <= 1'b0;
    end else if (in_take) begin
      s1_full <= 1'b1;
    end else if (advance) begin
      s1_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte  <= byte_value;
      s1_first <= first_byte;
      s1_last  <= last_byte;
    end
  end

  // Parser and statistics, both stepped by advance.
  ddp_rx_pkg::hdr_accept_t  hdr;
  ddp_rx_pkg::step_result_t res;
  ddp_rx_pkg::totals_t      totals_next;
  logic [3:0]               last_sequence;

  ddp_rx_parse #(
    .CHANNEL_MEMORY_DEPTH(CHANNEL_MEMORY_DEPTH)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .byte_value   (s1_byte),
    .first_byte   (s1_first),
    .last_byte    (s1_last),
    .channel_count(channel_count),
    .last_sequence(last_sequence),
    .hdr          (hdr),
    .res          (res)
  );

  ddp_rx_stats u_stats (
    .clk          (clk),
    .rst          (rst),
    .hdr          (hdr),
    .last_sequence(last_sequence),
    .totals_next  (totals_next)
  );

  // Output register: holds a finished item until the sink takes it; counters are
  // snapshotted as they stand after the item.
  logic load_out;
  assign load_out = advance && res.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      write_valid   <= res.write_valid;
      write_address <= res.write_address;
      write_data    <= res.write_data;
      packet_end    <= res.packet_end;
      status        <= res.status;
      push_res      <= res.push;
      packets_total <= totals_next.packets;
      bytes_total   <= totals_next.bytes;
      errors_total  <= totals_next.errors;
      min_channel   <= totals_next.min_channel;
      max_channel   <= totals_next.max_channel;
    end
  end

  // A write never points past the configured channel range.
  `DDP_ASSERT_IMPLY(a_write_in_range, out_valid && write_valid,
    {1'b0, write_address} < channel_count, "write beyond channel_count")
  // Status and push are only reported on the last byte of a packet.
  `DDP_ASSERT_IMPLY(a_status_at_end, out_valid && !packet_end,
    status == ddp_rx_pkg::STATUS_IGNORED && !push_res, "status outside packet end")
  // Push is only reported for an accepted packet.
  `DDP_ASSERT_IMPLY(a_push_accepted, out_valid && push_res,
    status != ddp_rx_pkg::STATUS_IGNORED, "push on ignored packet")
  // A held item in the input register moves on once the output side is free.
  `DDP_ASSERT_NEXT(a_input_drains, s1_full && !out_valid && !in_valid,
    !s1_full, "input register failed to drain")

endmodule

/* bench/ddp_rx_mirror_pkg.sv */
`timescale 1ns / 1ps

package ddp_rx_mirror_pkg;
  import ddp_rx_pkg::*;

  localparam int unsigned MEM_DEPTH  = 262144;

  // One result of the core, in port order.
  typedef struct packed {
    logic        write_valid;
    logic [17:0] write_address;
    logic [7:0]  write_data;
    logic        packet_end;
    logic [2:0]  status;
    logic        push;
    logic [31:0] packets;
    logic [47:0] bytes;
    logic [31:0] errors;
    logic [27:0] min_channel;
    logic [32:0] max_channel;
  } rx_outcome_t;

  // Mirror of the receiver: parser state, counters and the results still owed.
  class ddp_rx_mirror;
    logic [18:0] chan_count;
    phase_t      phase;
    logic [15:0] pos;
    logic [7:0]  flags;
    logic [3:0]  seq;
    logic        id_ok;
    logic [31:0] offset;
    logic [15:0] length;
    logic        seq_bad;
    logic        overflow;
    logic [3:0]  last_seq;
    logic [31:0] packets;
    logic [47:0] bytes;
    logic [31:0] errors;
    logic [27:0] lowest;
    logic [32:0] highest;
    rx_outcome_t owed[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned ends_seen;

    function new();
      chan_count   = CHANNEL_COUNT_RESET;
      phase        = PH_IDLE;
      pos          = '0;
      flags        = '0;
      seq          = SEQ_NONE;
      id_ok        = 1'b0;
      offset       = '0;
      length       = '0;
      seq_bad      = 1'b0;
      overflow     = 1'b0;
      last_seq     = SEQ_NONE;
      packets      = '0;
      bytes        = '0;
      errors       = '0;
      lowest       = LOWEST_RESET;
      highest      = '0;
      mismatches   = 0;
      results_seen = 0;
      ends_seen    = 0;
    endfunction

    function void set_channel_count(logic [18:0] value);
      chan_count = value;
    endfunction

    function int unsigned backlog();
      return owed.size();
    endfunction

    // Accepted byte: advance the parser and queue the result it causes, if any.
    function void take_byte(logic [7:0] b, logic first, logic last);
      rx_outcome_t r;
      logic        wr;
      logic        bad;
      logic [15:0] hlen;
      logic [32:0] addr_sum;
      logic [32:0] lo;
      logic [32:0] hi;
      r  = '0;
      wr = 1'b0;
      if (first) begin
        phase    = PH_HEADER;
        pos      = '0;
        flags    = '0;
        seq      = SEQ_NONE;
        id_ok    = 1'b0;
        offset   = '0;
        length   = '0;
        seq_bad  = 1'b0;
        overflow = 1'b0;
      end
      if (phase == PH_IDLE) return;

      if (phase == PH_HEADER) begin
        case (pos)
          POS_FLAGS:    flags = b;
          POS_SEQUENCE: seq = b[3:0];
          POS_ID:       id_ok = (b == ID_ACCEPT);
          POS_OFFSET_0, POS_OFFSET_1, POS_OFFSET_2, POS_OFFSET_3:
            offset = {offset[23:0], b};
          POS_LENGTH_HI, POS_LENGTH_LO:
            length = {length[7:0], b};
          default: ;
        endcase
        pos  = pos + 16'd1;
        hlen = flags[FLAG_TIMECODE_BIT] ? HDR_LEN_TIMECODE : HDR_LEN_BASE;
        if (pos >= hlen) begin
          if (id_ok) begin
            lo      = {1'b0, offset} + 33'd1;
            hi      = {1'b0, offset} + {17'd0, length};
            packets = packets + 32'd1;
            bytes   = bytes + {32'd0, length};
            if (seq != SEQ_NONE) begin
              bad = 1'b0;
              if (last_seq != SEQ_NONE) begin
                if (seq == SEQ_FIRST) bad = (last_seq != SEQ_WRAP);
                else bad = ((seq - SEQ_FIRST) != last_seq);
              end
              if (bad) begin
                errors  = errors + 32'd1;
                seq_bad = 1'b1;
              end
              last_seq = seq;
            end
            if (lo < {5'd0, lowest}) lowest = lo[27:0];
            if (hi > highest) highest = hi;
          end
          phase = PH_PAYLOAD;
          pos   = '0;
        end
      end else begin
        if (id_ok && pos < length) begin
          addr_sum = {1'b0, offset} + {17'd0, pos};
          if (addr_sum < {14'd0, chan_count} && addr_sum < MEM_DEPTH) begin
            wr              = 1'b1;
            r.write_address = addr_sum[17:0];
            r.write_data    = b;
          end else begin
            overflow = 1'b1;
          end
        end
        if (pos != POS_MAX) pos = pos + 16'd1;
      end

      if (!wr && !last) return;
      r.write_valid = wr;
      if (last) begin
        r.packet_end = 1'b1;
        r.status     = STATUS_IGNORED;
        if (phase == PH_PAYLOAD && id_ok) begin
          if (seq_bad && overflow) r.status = STATUS_BOTH;
          else if (overflow)       r.status = STATUS_OVF;
          else if (seq_bad)        r.status = STATUS_SEQ;
          else                     r.status = STATUS_OK;
          r.push = flags[FLAG_PUSH_BIT];
        end
        phase = PH_IDLE;
        id_ok = 1'b0;
      end
      r.packets     = packets;
      r.bytes       = bytes;
      r.errors      = errors;
      r.min_channel = lowest;
      r.max_channel = highest;
      owed.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
    endfunction

    // Accepted result: compare with the oldest owed one.
    function void check_output(rx_outcome_t got);
      rx_outcome_t want;
      results_seen++;
      if (owed.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got write_address 0x%0h",
                 $time, got.write_address);
        return;
      end
      want = owed.pop_front();
      if (want.packet_end) ends_seen++;
      compare_field("write_valid", want.write_valid, got.write_valid);
      compare_field("write_address", want.write_address, got.write_address);
      compare_field("write_data", want.write_data, got.write_data);
      compare_field("packet_end", want.packet_end, got.packet_end);
      compare_field("status", want.status, got.status);
      compare_field("push_res", want.push, got.push);
      compare_field("packets_total", want.packets, got.packets);
      compare_field("bytes_total", want.bytes, got.bytes);
      compare_field("errors_total", want.errors, got.errors);
      compare_field("min_channel", want.min_channel, got.min_channel);
      compare_field("max_channel", want.max_channel, got.max_channel);
    endfunction
  endclass

endpackage

/* bench/tb_ddp_packet_receiver_core.sv */
`timescale 1ns / 1ps

module tb_ddp_packet_receiver_core;
  import ddp_rx_pkg::*;
  import ddp_rx_mirror_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned ITEMS_PER_SET = 290;
  localparam int unsigned SETTLE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_value = '0;
  logic        first_byte = 1'b0;
  logic        last_byte  = 1'b0;

  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic        write_valid;
  logic [17:0] write_address;
  logic [7:0]  write_data;
  logic        packet_end;
  logic [2:0]  status;
  logic        push_res;
  logic [31:0] packets_total;
  logic [47:0] bytes_total;
  logic [31:0] errors_total;
  logic [27:0] min_channel;
  logic [32:0] max_channel;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Pacing: chance in a hundred of a sender gap / receiver stall per cycle
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  int unsigned items_sent   = 0;
  int unsigned stray_sent   = 0;
  int unsigned cycle_count  = 0;
  logic [18:0] chan_cfg     = CHANNEL_COUNT_RESET;
  logic [3:0]  next_seq     = SEQ_FIRST;

  rx_outcome_t  out_now;
  ddp_rx_mirror mirror = new();

  ddp_packet_receiver_core #(.CHANNEL_MEMORY_DEPTH(MEM_DEPTH)) u_top (.*);

  always #10 clk = ~clk;

  assign out_now = {write_valid, write_address, write_data, packet_end, status, push_res,
                    packets_total, bytes_total, errors_total, min_channel, max_channel};

  // Receiver stall and run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_stall   <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results still owed",
               cycle_count, mirror.backlog());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Both handshakes are sampled at the edge. The result check goes first: an item
  // accepted at this edge cannot have its result out before the next one.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) mirror.check_output(out_now);
      if (in_valid && !in_stall) mirror.take_byte(byte_value, first_byte, last_byte);
    end
  end

  // One item on the input channel; returns in the step of its acceptance with
  // valid still high, so the next call never lowers and raises it in one step.
  task automatic send_item(input logic [7:0] b, input logic first, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    byte_value <= b;
    first_byte <= first;
    last_byte  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Builds a DDP packet and sends it. cut_at > 0 stops after that many bytes;
  // with closed low the packet is left open (the next first mark abandons it).
  task automatic send_packet(input logic [7:0] flags, input logic [7:0] seq_byte,
                             input logic [7:0] id, input logic [31:0] offset,
                             input logic [15:0] length, input int n_payload,
                             input int cut_at, input bit closed);
    logic [7:0] frame[$];
    int n;
    frame = {flags, seq_byte, 8'($urandom), id, offset[31:24], offset[23:16],
             offset[15:8], offset[7:0], length[15:8], length[7:0]};
    if (flags[FLAG_TIMECODE_BIT]) repeat (4) frame.push_back(8'($urandom));
    repeat (n_payload) frame.push_back(8'($urandom));
    n = (cut_at > 0 && cut_at < frame.size()) ? cut_at : frame.size();
    for (int i = 0; i < n; i++) begin
      send_item(frame[i], i == 0, closed && (i == n - 1));
      items_sent++;
    end
  endtask

  // Mostly well-formed packets with the right id and sequence, laced with stray
  // bytes, foreign ids, broken sequences, truncated headers and abandoned packets.
  task automatic send_random_packet();
    logic [7:0]  flags;
    logic [3:0]  nib;
    logic [7:0]  id;
    logic [31:0] offset;
    logic [15:0] length;
    int pick, lim, n_pay, cut, hlen;
    bit closed;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 3)) begin
        send_item(8'($urandom), 1'b0, 1'($urandom));
        stray_sent++;
      end
    end
    flags = 8'($urandom);
    pick  = $urandom_range(99);
    if (pick < 70)      nib = next_seq;
    else if (pick < 80) nib = SEQ_NONE;
    else                nib = 4'($urandom);
    if (nib != SEQ_NONE) next_seq = (nib == SEQ_WRAP) ? SEQ_FIRST : nib + 4'd1;
    id = ($urandom_range(99) < 85) ? ID_ACCEPT : 8'($urandom);

    pick = $urandom_range(99);
    if (pick < 40)      offset = $urandom_range(0, 255);
    else if (pick < 60) offset = chan_cfg - $urandom_range(0, 24);
    else if (pick < 70) offset = MEM_DEPTH - $urandom_range(0, 24);
    else if (pick < 80) offset = $urandom;
    else if (pick < 90) offset = '0;
    else                offset = 32'hFFFF_FFFF - $urandom_range(0, 3);

    pick = $urandom_range(99);
    if (pick < 80)      length = 16'($urandom_range(0, 20));
    else if (pick < 90) length = 16'($urandom);
    else                length = POS_MAX;

    // Short payloads keep the run brisk even for huge lengths
    lim  = (length > 16'd24) ? 24 : int'(length);
    pick = $urandom_range(99);
    if (pick < 70)      n_pay = lim;
    else if (pick < 85) n_pay = $urandom_range(0, lim);
    else                n_pay = lim + $urandom_range(1, 4);

    hlen = flags[FLAG_TIMECODE_BIT] ? int'(HDR_LEN_TIMECODE) : int'(HDR_LEN_BASE);
    pick = $urandom_range(99);
    if (pick < 85) begin
      cut = 0;
      closed = 1'b1;
    end else if (pick < 92) begin
      cut = $urandom_range(1, hlen - 1);
      closed = 1'b1;
    end else begin
      cut = $urandom_range(1, hlen + n_pay);
      closed = 1'b0;
    end
    send_packet(flags, {4'($urandom), nib}, id, offset, length, n_pay, cut, closed);
  endtask

  // Drop valid, let the last item reach the mirror, wait for every owed result
  // and then for the pipeline to drain of items that give none.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mirror.backlog() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_channel_count(input logic [18:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_CHANNEL_COUNT;
    pwdata  <= {13'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    chan_cfg = value;
    mirror.set_channel_count(value);
  endtask

  initial begin
    logic [18:0] plan [6];
    int unsigned target;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: the register at its reset value, then a stray byte with a last
    // mark (ignored), a one-byte packet, a packet that stops inside its
    // header, and a push packet with sequence 15 writing the top two
    // channels, its last byte carrying both the write and the packet end.
    write_channel_count(CHANNEL_COUNT_RESET);
    send_item(8'hFF, 1'b0, 1'b1);
    stray_sent++;
    send_item(8'h00, 1'b1, 1'b1);
    items_sent++;
    send_packet(8'h00, 8'h00, ID_ACCEPT, 32'd0, 16'd0, 0, 6, 1'b1);
    send_packet(8'h01, 8'hFF, ID_ACCEPT, MEM_DEPTH - 2, 16'd2, 2, 0, 1'b1);

    // Six register settings, two per pacing regime; zero and the top of the
    // range among them.
    plan[0] = 19'($urandom_range(1024, MEM_DEPTH - 1));
    plan[1] = '0;
    plan[2] = 19'($urandom_range(1, 300));
    plan[3] = CHANNEL_COUNT_RESET;
    plan[4] = 19'($urandom_range(300, MEM_DEPTH - 1));
    plan[5] = 19'(MEM_DEPTH - 1);
    for (int k = 0; k < 6; k++) begin
      settle();
      gap_pct   = (k < 2) ? 6 : (k < 4) ? 62 : 0;
      stall_pct = (k < 2) ? 62 : (k < 4) ? 6 : 0;
      write_channel_count(plan[k]);
      target = items_sent + ITEMS_PER_SET;
      while (items_sent < target) send_random_packet();
    end
    settle();

    $display("Sent %0d packet bytes and %0d stray bytes over six channel_count settings",
             items_sent, stray_sent);
    $display("and three pacing regimes; %0d results checked, %0d of them packet ends.",
             mirror.results_seen, mirror.ends_seen);
    if (mirror.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
